FILE: design/triangle_coverage_alpha_blend_defines.svh
// Assertion macros used by the checker file tca_checker.sv.
`ifndef TRIANGLE_COVERAGE_ALPHA_BLEND_DEFINES_SVH
`define TRIANGLE_COVERAGE_ALPHA_BLEND_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tca_pkg.sv
`timescale 1ns / 1ps

package tca_pkg;

    // Defaults for the top-level parameters
    localparam int PIXEL_COORD_BITS_DEF = 12;
    localparam int VERTEX_FRAC_BITS_DEF = 4;

    // Fixed field widths
    localparam int PIX_W   = 12;
    localparam int CH_W    = 8;
    localparam int REG_W   = 32;
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int SUM_W   = CROSS_W + 2;
    localparam int ALPHA_W = 16;
    localparam int NUM_W   = 24;

    // Pipeline depth: stage 6 is the output register
    localparam int NSTAGE = 6;

    // Register indexes
    typedef enum logic [1:0] {
        REG_VERTEX_A   = 2'd0,
        REG_VERTEX_B   = 2'd1,
        REG_VERTEX_C   = 2'd2,
        REG_FILL_COLOR = 2'd3
    } cfg_reg_t;

    // Per-stage load enables
    typedef struct packed {
        logic [NSTAGE:1] en;
    } tca_ctl_t;

endpackage

FILE: design/tca_cover.sv
`timescale 1ns / 1ps

module tca_cover
    import tca_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = PIXEL_COORD_BITS_DEF,
    parameter int VERTEX_FRAC_BITS = VERTEX_FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  tca_ctl_t         ctl,
    input  logic [PIX_W-1:0] pixel_x,
    input  logic [PIX_W-1:0] pixel_y,
    input  logic [REG_W-1:0] vertex_a,
    input  logic [REG_W-1:0] vertex_b,
    input  logic [REG_W-1:0] vertex_c,
    output logic             hit
);

    localparam int UB  = (PIXEL_COORD_BITS < PIX_W) ? PIXEL_COORD_BITS : PIX_W;
    localparam int TOL = (1 << (2 * VERTEX_FRAC_BITS)) / 100;

    logic [COORD_W-1:0] px, py, ax, ay, bx, by, cx, cy;

    // stage 1: coordinate differences
    logic signed [DIFF_W-1:0] dpxc_reg, dpyc_reg, dpxb_reg, dpyb_reg;
    logic signed [DIFF_W-1:0] bxc_reg, byc_reg, axc_reg, ayc_reg, axb_reg, ayb_reg;
    // stage 2: products
    logic signed [PROD_W-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg;
    logic signed [PROD_W-1:0] p3a_reg, p3b_reg, pta_reg, ptb_reg;
    // stage 3: absolute doubled areas
    logic [CROSS_W-1:0] s1_reg, s2_reg, s3_reg, ta_reg;
    logic [CROSS_W-1:0] s1_next, s2_next, s3_next, ta_next;
    // stage 4: tolerance compare
    logic               hit_reg;
    logic [SUM_W-1:0]   sum;

    function automatic logic signed [DIFF_W-1:0] diff(input logic [COORD_W-1:0] p,
                                                       input logic [COORD_W-1:0] q);
        return $signed({1'b0, p}) - $signed({1'b0, q});
    endfunction

    function automatic logic [CROSS_W-1:0] abs_cross(input logic signed [PROD_W-1:0] m,
                                                      input logic signed [PROD_W-1:0] n);
        logic signed [CROSS_W-1:0] c;
        c = CROSS_W'(m) - CROSS_W'(n);
        return c[CROSS_W-1] ? CROSS_W'(-c) : CROSS_W'(c);
    endfunction

    // scale pixel to vertex fixed point
    assign px = COORD_W'(pixel_x[UB-1:0]) << VERTEX_FRAC_BITS;
    assign py = COORD_W'(pixel_y[UB-1:0]) << VERTEX_FRAC_BITS;
    assign ax = vertex_a[31:16];
    assign ay = vertex_a[15:0];
    assign bx = vertex_b[31:16];
    assign by = vertex_b[15:0];
    assign cx = vertex_c[31:16];
    assign cy = vertex_c[15:0];

    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            dpxc_reg <= diff(px, cx);
            dpyc_reg <= diff(py, cy);
            dpxb_reg <= diff(px, bx);
            dpyb_reg <= diff(py, by);
            bxc_reg  <= diff(bx, cx);
            byc_reg  <= diff(by, cy);
            axc_reg  <= diff(ax, cx);
            ayc_reg  <= diff(ay, cy);
            axb_reg  <= diff(ax, bx);
            ayb_reg  <= diff(ay, by);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            p1a_reg <= dpxc_reg * byc_reg;
            p1b_reg <= bxc_reg * dpyc_reg;
            p2a_reg <= dpxc_reg * ayc_reg;
            p2b_reg <= axc_reg * dpyc_reg;
            p3a_reg <= dpxb_reg * ayb_reg;
            p3b_reg <= axb_reg * dpyb_reg;
            pta_reg <= axc_reg * byc_reg;
            ptb_reg <= bxc_reg * ayc_reg;
        end
    end

    always_comb
    begin
        s1_next = abs_cross(p1a_reg, p1b_reg);
        s2_next = abs_cross(p2a_reg, p2b_reg);
        s3_next = abs_cross(p3a_reg, p3b_reg);
        ta_next = abs_cross(pta_reg, ptb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            ta_reg <= ta_next;
        end
    end

    // excess of sub-areas over the triangle area
    assign sum = SUM_W'(s1_reg) + SUM_W'(s2_reg) + SUM_W'(s3_reg) - SUM_W'(ta_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.en[4])
        begin
            hit_reg <= ($signed(sum) <= $signed(SUM_W'(TOL)));
        end
    end

    assign hit = hit_reg;

endmodule

FILE: design/tca_blend.sv
`timescale 1ns / 1ps

module tca_blend
    import tca_pkg::*;
(
    input  logic             clk,
    input  tca_ctl_t         ctl,
    input  logic             hit,
    input  logic [REG_W-1:0] fill_color,
    input  logic [CH_W-1:0]  dest_red,
    input  logic [CH_W-1:0]  dest_green,
    input  logic [CH_W-1:0]  dest_blue,
    input  logic [CH_W-1:0]  dest_alpha,
    output logic [CH_W-1:0]  out_red,
    output logic [CH_W-1:0]  out_green,
    output logic [CH_W-1:0]  out_blue,
    output logic [CH_W-1:0]  out_alpha,
    output logic             covered
);

    logic [CH_W-1:0] fa;
    logic [CH_W-1:0] fc [3];
    logic [CH_W-1:0] dc_in [3];

    // stage 1
    logic [ALPHA_W-1:0] w1_reg;
    logic [ALPHA_W-1:0] pf1_reg [3];
    logic [CH_W-1:0]    fa1_reg;
    logic [CH_W-1:0]    dc1_reg [3];
    logic [CH_W-1:0]    da1_reg;
    // stage 2
    logic [ALPHA_W-1:0] a2_reg;
    logic [NUM_W-1:0]   num2_reg [3];
    logic [CH_W-1:0]    dc2_reg [3];
    logic [CH_W-1:0]    da2_reg;
    // stages 3..5: divider lanes
    logic [ALPHA_W-1:0] a3_reg, a4_reg, a5_reg;
    logic [NUM_W-1:0]   rem3_reg [3], rem4_reg [3], rem5_reg [3];
    logic [CH_W-1:0]    q3_reg [3], q4_reg [3], q5_reg [3];
    logic [CH_W-1:0]    dc3_reg [3], dc4_reg [3], dc5_reg [3];
    logic [CH_W-1:0]    da3_reg, da4_reg, da5_reg;
    logic               cov5_reg;
    // stage 6: output register
    logic [CH_W-1:0]    out_c_reg [3];
    logic [CH_W-1:0]    out_a_reg;
    logic               cov6_reg;

    logic [NUM_W+1:0]   t3 [3], t4 [3], t5 [3], t6 [3];
    logic [ALPHA_W:0]   a_div;

    // two restoring division steps: {quotient bits, remainder}
    function automatic logic [NUM_W+1:0] div2(input logic [NUM_W-1:0] rem,
                                              input logic [ALPHA_W-1:0] a,
                                              input int sh);
        logic [NUM_W-1:0] r;
        logic [NUM_W-1:0] d;
        logic [1:0]       q;
        r = rem;
        d = NUM_W'(a) << (sh + 1);
        q[1] = (r >= d);
        if (q[1])
        begin
            r = r - d;
        end
        d = NUM_W'(a) << sh;
        q[0] = (r >= d);
        if (q[0])
        begin
            r = r - d;
        end
        return {q, r};
    endfunction

    assign fa       = fill_color[7:0];
    assign fc[0]    = fill_color[31:24];
    assign fc[1]    = fill_color[23:16];
    assign fc[2]    = fill_color[15:8];
    assign dc_in[0] = dest_red;
    assign dc_in[1] = dest_green;
    assign dc_in[2] = dest_blue;

    // stage 1: weights
    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            w1_reg  <= ALPHA_W'(8'd255 - fa) * ALPHA_W'(dest_alpha);
            fa1_reg <= fa;
            da1_reg <= dest_alpha;
            for (int k = 0; k < 3; k++)
            begin
                pf1_reg[k] <= ALPHA_W'(fa) * ALPHA_W'(fc[k]);
                dc1_reg[k] <= dc_in[k];
            end
        end
    end

    // stage 2: combined alpha and numerators
    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            a2_reg  <= w1_reg + (ALPHA_W'(fa1_reg) << 8) - ALPHA_W'(fa1_reg);
            da2_reg <= da1_reg;
            for (int k = 0; k < 3; k++)
            begin
                num2_reg[k] <= NUM_W'(w1_reg) * NUM_W'(dc1_reg[k])
                               + (NUM_W'(pf1_reg[k]) << 8) - NUM_W'(pf1_reg[k]);
                dc2_reg[k]  <= dc1_reg[k];
            end
        end
    end

    // divider steps, two quotient bits per stage
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t3[k] = div2(num2_reg[k], a2_reg, 6);
            t4[k] = div2(rem3_reg[k], a3_reg, 4);
            t5[k] = div2(rem4_reg[k], a4_reg, 2);
            t6[k] = div2(rem5_reg[k], a5_reg, 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            a3_reg  <= a2_reg;
            da3_reg <= da2_reg;
            for (int k = 0; k < 3; k++)
            begin
                rem3_reg[k] <= t3[k][NUM_W-1:0];
                q3_reg[k]   <= {6'd0, t3[k][NUM_W+1:NUM_W]};
                dc3_reg[k]  <= dc2_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[4])
        begin
            a4_reg  <= a3_reg;
            da4_reg <= da3_reg;
            for (int k = 0; k < 3; k++)
            begin
                rem4_reg[k] <= t4[k][NUM_W-1:0];
                q4_reg[k]   <= {q3_reg[k][5:0], t4[k][NUM_W+1:NUM_W]};
                dc4_reg[k]  <= dc3_reg[k];
            end
        end
    end

    // coverage joins here; zero alpha means pass through
    always_ff @(posedge clk)
    begin
        if (ctl.en[5])
        begin
            a5_reg   <= a4_reg;
            da5_reg  <= da4_reg;
            cov5_reg <= hit && (a4_reg != '0);
            for (int k = 0; k < 3; k++)
            begin
                rem5_reg[k] <= t5[k][NUM_W-1:0];
                q5_reg[k]   <= {q4_reg[k][5:0], t5[k][NUM_W+1:NUM_W]};
                dc5_reg[k]  <= dc4_reg[k];
            end
        end
    end

    // floor(a / 255) for a below 2^16
    assign a_div = (ALPHA_W + 1)'(a5_reg) + (ALPHA_W + 1)'(a5_reg >> 8) + 1'b1;

    // stage 6: select blended or original color and alpha
    always_ff @(posedge clk)
    begin
        if (ctl.en[6])
        begin
            cov6_reg  <= cov5_reg;
            out_a_reg <= cov5_reg ? a_div[15:8] : da5_reg;
            for (int k = 0; k < 3; k++)
            begin
                out_c_reg[k] <= cov5_reg ? {q5_reg[k][5:0], t6[k][NUM_W+1:NUM_W]}
                                         : dc5_reg[k];
            end
        end
    end

    assign out_red   = out_c_reg[0];
    assign out_green = out_c_reg[1];
    assign out_blue  = out_c_reg[2];
    assign out_alpha = out_a_reg;
    assign covered   = cov6_reg;

endmodule

FILE: design/triangle_coverage_alpha_blend.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while out_stall does not back up the
// pipeline; six register stages, the coverage multipliers and a
// two-bit-per-stage restoring divider set the depth.
// Reset (rst_n low, asynchronous): configuration registers read 0, valid bits
// clear, pipeline empty; datapath registers are not reset.

module triangle_coverage_alpha_blend
    import tca_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = PIXEL_COORD_BITS_DEF,
    parameter int VERTEX_FRAC_BITS = VERTEX_FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] pixel_x,
    input  logic [PIX_W-1:0] pixel_y,
    input  logic [CH_W-1:0]  dest_red,
    input  logic [CH_W-1:0]  dest_green,
    input  logic [CH_W-1:0]  dest_blue,
    input  logic [CH_W-1:0]  dest_alpha,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [CH_W-1:0]  out_red,
    output logic [CH_W-1:0]  out_green,
    output logic [CH_W-1:0]  out_blue,
    output logic [CH_W-1:0]  out_alpha,
    output logic             covered
);

    logic [REG_W-1:0] vertex_a_reg, vertex_b_reg, vertex_c_reg, fill_color_reg;
    logic [NSTAGE:1]  valid_reg;
    logic [NSTAGE:1]  ready;
    tca_ctl_t         ctl;
    logic             hit;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_a_reg   <= '0;
            vertex_b_reg   <= '0;
            vertex_c_reg   <= '0;
            fill_color_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_VERTEX_A:   vertex_a_reg   <= cfg_wdata;
                REG_VERTEX_B:   vertex_b_reg   <= cfg_wdata;
                REG_VERTEX_C:   vertex_c_reg   <= cfg_wdata;
                REG_FILL_COLOR: fill_color_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // a stage loads when empty or when the stage after it moves
    always_comb
    begin
        ready[NSTAGE] = !valid_reg[NSTAGE] || !out_stall;
        for (int s = NSTAGE - 1; s >= 1; s--)
        begin
            ready[s] = !valid_reg[s] || ready[s + 1];
        end
    end

    assign ctl.en = ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int s = 2; s <= NSTAGE; s++)
            begin
                if (ready[s])
                begin
                    valid_reg[s] <= valid_reg[s - 1];
                end
            end
        end
    end

    assign in_stall  = !ready[1];
    assign out_valid = valid_reg[NSTAGE];

    tca_cover #(
        .PIXEL_COORD_BITS (PIXEL_COORD_BITS),
        .VERTEX_FRAC_BITS (VERTEX_FRAC_BITS)
    ) u_cover (
        .clk      (clk),
        .ctl      (ctl),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .vertex_a (vertex_a_reg),
        .vertex_b (vertex_b_reg),
        .vertex_c (vertex_c_reg),
        .hit      (hit)
    );

    tca_blend u_blend (
        .clk        (clk),
        .ctl        (ctl),
        .hit        (hit),
        .fill_color (fill_color_reg),
        .dest_red   (dest_red),
        .dest_green (dest_green),
        .dest_blue  (dest_blue),
        .dest_alpha (dest_alpha),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .covered    (covered)
    );

endmodule

FILE: design/tca_checker.sv
`timescale 1ns / 1ps
`include "triangle_coverage_alpha_blend_defines.svh"

module tca_checker
    import tca_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [CH_W-1:0]  out_red,
    input logic [CH_W-1:0]  out_green,
    input logic [CH_W-1:0]  out_blue,
    input logic [CH_W-1:0]  out_alpha,
    input logic             covered
);

    // a held result keeps its payload
    `TCA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha) && $stable(covered), "stalled result changed")

    // input backs up only when the output is full and stalled
    `TCA_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

    // a full, stalled pipeline stays full while the stall holds
    `TCA_ASSERT_NEXT(a_stall_keep, in_stall && out_stall, in_stall || !out_stall, "full pipeline drained while stalled")

endmodule

bind triangle_coverage_alpha_blend tca_checker u_tca_checker (.*);
